// ===== src/mfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the motor feedback frame decoder.
package mfd_pkg;

   localparam int FRAME_BYTES     = 10;
   localparam int CRC_BYTES       = FRAME_BYTES - 1;
   localparam int STORE_BYTES     = 8;
   localparam int STORE_IDX_W     = $clog2(STORE_BYTES);
   localparam int POSITION_COUNTS = 32768;
   localparam int POS_W           = $clog2(POSITION_COUNTS);
   localparam int UNW_W           = 34;
   localparam int RSP_DATA_W      = 112;

   localparam logic [7:0] CRC_POLY       = 8'h8C;
   localparam logic [7:0] MOTOR_ID_RESET = 8'd17;
   localparam logic [7:0] COUNT_MAX      = 8'hFF;
   localparam logic [7:0] CRC_LAST_INDEX = 8'(CRC_BYTES);
   localparam logic [7:0] EOF_INDEX      = 8'(FRAME_BYTES - 1);

   localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;
   localparam logic signed [15:0] TURN_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      ST_APPLIED    = 3'd0,
      ST_ZEROED     = 3'd1,
      ST_BAD_LENGTH = 3'd2,
      ST_BAD_CRC    = 3'd3,
      ST_OTHER_ID   = 3'd4
   } status_type;

   // A checked frame on its way from the assembler to the position tracker.
   typedef struct packed {
      status_type        check;
      logic [7:0]        length;
      logic signed [15:0] current_raw;
      logic signed [15:0] speed_rpm;
      logic [POS_W-1:0]  position;
   } frame_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         frame_length;
      logic signed [15:0] current_raw;
      logic signed [15:0] speed_rpm;
      logic signed [16:0] speed_change;
      logic signed [15:0] turn_count;
      logic signed [31:0] unwrapped_position;
   } result_type;

   // Reflected CRC-8, one byte folded in bit by bit.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== src/mfd_frame_assembler.sv =====
// Collects request bytes into a frame, runs the CRC and checks length, CRC and identifier.
module mfd_frame_assembler import mfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] motor_id,
   input  logic       byte_valid,
   output logic       byte_ready,
   input  logic [7:0] rx_byte,
   input  logic       end_of_frame,
   output logic       frm_valid,
   input  logic       frm_ready,
   output frame_type  frm
);

   logic [7:0]     count_ff, count_in;
   logic [7:0]     crc_ff, crc_in;
   logic [7:0]     store_ff [STORE_BYTES];
   logic           frm_valid_ff, frm_valid_in;
   frame_type      frm_ff, frm_in;
   logic           accept;
   logic [7:0]     length;
   logic [15:0]    pos_word;

   assign byte_ready = !frm_valid_ff || frm_ready;
   assign accept     = byte_valid && byte_ready;
   assign frm_valid  = frm_valid_ff;
   assign frm        = frm_ff;

   assign length   = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 8'd1;
   assign pos_word = {store_ff[6], store_ff[7]};

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      frm_valid_in = frm_valid_ff;
      frm_in       = frm_ff;
      if (frm_ready) begin
         frm_valid_in = 1'b0;
      end
      if (accept) begin
         if (count_ff < CRC_LAST_INDEX) begin
            crc_in = crc8_update(crc_ff, rx_byte);
         end
         count_in = length;
         if (end_of_frame) begin
            count_in            = '0;
            crc_in              = '0;
            frm_valid_in        = 1'b1;
            frm_in.length       = length;
            frm_in.current_raw  = $signed({store_ff[2], store_ff[3]});
            frm_in.speed_rpm    = $signed({store_ff[4], store_ff[5]});
            frm_in.position     = pos_word[POS_W-1:0];
            // The closing byte of a well-sized frame is the CRC byte itself.
            if (count_ff != EOF_INDEX) begin
               frm_in.check = ST_BAD_LENGTH;
            end else if (crc_ff != rx_byte) begin
               frm_in.check = ST_BAD_CRC;
            end else if (store_ff[0] != motor_id) begin
               frm_in.check = ST_OTHER_ID;
            end else begin
               frm_in.check = ST_APPLIED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         crc_ff       <= '0;
         frm_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         frm_valid_ff <= frm_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frm_ff <= frm_in;
      if (accept && count_ff < 8'(STORE_BYTES)) begin
         store_ff[count_ff[STORE_IDX_W-1:0]] <= rx_byte;
      end
   end

`ifndef SYNTHESIS
   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_frame |=> count_ff == '0 && crc_ff == '0 && frm_valid_ff)
      else $error("frame state not cleared after the closing byte");

   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      frm_valid_ff && !frm_ready |=> frm_valid_ff && $stable(frm_ff))
      else $error("checked frame lost while the tracker was stalled");
`endif

endmodule

// ===== src/mfd_position_tracker.sv =====
// Decodes checked frames, tracks turns and speed, and holds the result register.
module mfd_position_tracker import mfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       frm_valid,
   output logic       frm_ready,
   input  frame_type  frm,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam logic signed [POS_W:0]     POS_HALF = (POS_W + 1)'(POSITION_COUNTS / 2);
   localparam logic signed [UNW_W-1:0]   UNW_HI   = UNW_W'(32'h7FFF_FFFF);
   localparam logic signed [UNW_W-1:0]   UNW_LO   = -UNW_HI - UNW_W'(1);

   logic               started_ff, started_in;
   logic [POS_W-1:0]   prev_pos_ff, prev_pos_in;
   logic [POS_W-1:0]   zero_pos_ff, zero_pos_in;
   logic signed [15:0] turns_ff, turns_in;
   logic signed [15:0] prev_rpm_ff, prev_rpm_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               advance;
   logic signed [POS_W:0]   pos_delta;
   logic signed [POS_W:0]   pos_offset;
   logic signed [15:0]      turns_next;
   logic signed [UNW_W-1:0] unw_wide;
   logic signed [31:0]      unw_sat;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign frm_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign pos_delta  = $signed({1'b0, frm.position}) - $signed({1'b0, prev_pos_ff});
   assign pos_offset = $signed({1'b0, frm.position}) - $signed({1'b0, zero_pos_ff});

   // A jump of more than half the range is taken as a wrap in the other direction.
   always_comb begin
      turns_next = turns_ff;
      if (pos_delta > POS_HALF) begin
         if (turns_ff != TURN_MIN) begin
            turns_next = turns_ff - 16'sd1;
         end
      end else if (pos_delta < -POS_HALF) begin
         if (turns_ff != TURN_MAX) begin
            turns_next = turns_ff + 16'sd1;
         end
      end
   end

   assign unw_wide = (UNW_W'(turns_next) <<< POS_W) + UNW_W'(pos_offset);

   always_comb begin
      if (unw_wide > UNW_HI) begin
         unw_sat = 32'sh7FFF_FFFF;
      end else if (unw_wide < UNW_LO) begin
         unw_sat = 32'sh8000_0000;
      end else begin
         unw_sat = unw_wide[31:0];
      end
   end

   always_comb begin
      started_in   = started_ff;
      prev_pos_in  = prev_pos_ff;
      zero_pos_in  = zero_pos_ff;
      turns_in     = turns_ff;
      prev_rpm_in  = prev_rpm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = frm_valid;
         if (frm_valid) begin
            rsp_in.status       = frm.check;
            rsp_in.frame_length = frm.length;
            rsp_in.current_raw  = '0;
            rsp_in.speed_rpm    = '0;
            rsp_in.speed_change = '0;
            rsp_in.turn_count   = '0;
            rsp_in.unwrapped_position = '0;
            if (frm.check == ST_APPLIED) begin
               rsp_in.current_raw = frm.current_raw;
               rsp_in.speed_rpm   = frm.speed_rpm;
               prev_rpm_in        = frm.speed_rpm;
               prev_pos_in        = frm.position;
               if (!started_ff) begin
                  rsp_in.status = ST_ZEROED;
                  started_in    = 1'b1;
                  zero_pos_in   = frm.position;
                  turns_in      = '0;
               end else begin
                  rsp_in.speed_change = 17'(frm.speed_rpm) - 17'(prev_rpm_ff);
                  rsp_in.turn_count   = turns_next;
                  rsp_in.unwrapped_position = unw_sat;
                  turns_in            = turns_next;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         prev_pos_ff  <= '0;
         zero_pos_ff  <= '0;
         turns_ff     <= '0;
         prev_rpm_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         prev_pos_ff  <= prev_pos_in;
         zero_pos_ff  <= zero_pos_in;
         turns_ff     <= turns_in;
         prev_rpm_ff  <= prev_rpm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("start flag dropped without a reset");

   a_first_frame_zeroed: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> rsp_valid_ff && rsp_ff.status == ST_ZEROED
         && rsp_ff.unwrapped_position == '0)
      else $error("first good frame did not report a zeroed position");

   a_rejected_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_APPLIED |->
         rsp_ff.turn_count == '0 && rsp_ff.speed_change == '0)
      else $error("turn or speed data reported for a frame that was not applied");
`endif

endmodule

// ===== src/motor_feedback_frame_decoder.sv =====
// Motor feedback frame decoder: top level with the identifier register and the two stages.
//
// Request channel (req_): one received reply byte per request, req_tlast on the last
// byte of a frame. Result channel (rsp_): one result per frame, issued for each request
// that carries req_tlast; status travels in rsp_tuser. Configuration: csr_we writes
// csr_wdata into the registered motor identifier.
// A byte is checked and folded into the CRC in the cycle it is taken; a closing byte
// produces a checked frame in the assembler's frame register in the next cycle, and
// the decoded result moves on into the result register, which drives rsp_tvalid, as
// soon as that register is free or being read. One request is taken every cycle while
// req_tready is high; the decode stage and the result register each hold one frame.
// When the receiver holds rsp_tready low, the result stays put, the checked frame
// waits behind it, and req_tready falls only once both are occupied.
// Reset clears the byte counter, CRC, start flag, turn counter and the saved position
// and speed, and sets the motor identifier to 17. The first good frame after reset
// sets the zero position.
module motor_feedback_frame_decoder import mfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte
   input  logic                  req_tlast,   // end_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_length, current_raw, speed_rpm, speed_change, turn_count,
   // unwrapped_position, zero padding
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,   // status
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata    // motor_id
);

   logic       [7:0] motor_id_ff;
   logic       frm_valid;
   logic       frm_ready;
   frame_type  frm;
   result_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         motor_id_ff <= MOTOR_ID_RESET;
      end else if (csr_we) begin
         motor_id_ff <= csr_wdata;
      end
   end

   mfd_frame_assembler u_assembler (
      .clock        (clock),
      .reset        (reset),
      .motor_id     (motor_id_ff),
      .byte_valid   (req_tvalid),
      .byte_ready   (req_tready),
      .rx_byte      (req_tdata),
      .end_of_frame (req_tlast),
      .frm_valid    (frm_valid),
      .frm_ready    (frm_ready),
      .frm          (frm)
   );

   mfd_position_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .frm_valid (frm_valid),
      .frm_ready (frm_ready),
      .frm       (frm),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {7'd0, rsp.unwrapped_position, rsp.turn_count, rsp.speed_change,
                       rsp.speed_rpm, rsp.current_raw, rsp.frame_length};

endmodule
